/* rtl/pled_pkg.sv */
`timescale 1ns / 1ps

package pled_pkg;

  localparam int LANES = 8;
  localparam int COLOUR_BITS = 24;

  localparam logic [1:0] OP_SET_PIXEL = 2'd0;
  localparam logic [1:0] OP_CLEAR     = 2'd1;
  localparam logic [1:0] OP_PAINT     = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic [1:0] CFG_BIT_TICKS       = 2'd0;
  localparam logic [1:0] CFG_ZERO_HIGH_TICKS = 2'd1;
  localparam logic [1:0] CFG_ONE_HIGH_TICKS  = 2'd2;
  localparam logic [1:0] CFG_RESET_GAP_TICKS = 2'd3;

  localparam logic [11:0] BIT_TICKS_RST       = 12'd210;
  localparam logic [11:0] ZERO_HIGH_TICKS_RST = 12'd70;
  localparam logic [11:0] ONE_HIGH_TICKS_RST  = 12'd140;
  localparam logic [15:0] RESET_GAP_TICKS_RST = 16'd8076;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_SEND = 2'd1;
  localparam logic [1:0] PHASE_GAP  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pled_in_t;

  typedef struct packed {
    logic [7:0] lane_levels;
    logic       busy_res;
    logic       paint_accepted;
  } pled_out_t;

  typedef struct packed {
    logic [11:0] bit_ticks;
    logic [11:0] zero_high_ticks;
    logic [11:0] one_high_ticks;
    logic [15:0] reset_gap_ticks;
  } pled_cfg_t;

  typedef struct packed {
    logic tick;
    logic paint;
  } pled_wave_ctl_t;

  typedef struct packed {
    logic [LANES-1:0] level;
    logic             sending;
    logic             sending_nxt;
    logic             paint_ok;
  } pled_wave_sts_t;

  localparam logic [7:0] GAMMA_ROM [0:255] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
    8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
    8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
    8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
    8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
    8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
    8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
    8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
    8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
    8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
    8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
    8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
    8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
    8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
    8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
    8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
    8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
    8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
    8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
    8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
    8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
    8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
  };

endpackage

/* rtl/pled_store.sv */
`timescale 1ns / 1ps

module pled_store
  import pled_pkg::*;
#(
  parameter int DEPTH = 768,
  parameter int AW = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [LANES-1:0] wdata,
  input  logic [AW-1:0]    a_addr,
  output logic [LANES-1:0] a_rdata,
  input  logic [AW-1:0]    b_addr,
  output logic [LANES-1:0] b_rdata
);

  logic [LANES-1:0] mem_r [0:DEPTH-1];
  logic [LANES-1:0] a_rdata_r;
  logic [LANES-1:0] b_rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    a_rdata_r <= mem_r[a_addr];
    // the waveform port sees a write in the same cycle
    if (we && (waddr == b_addr)) begin
      b_rdata_r <= wdata;
    end else begin
      b_rdata_r <= mem_r[b_addr];
    end
  end

  assign a_rdata = a_rdata_r;
  assign b_rdata = b_rdata_r;

endmodule

/* rtl/pled_wave.sv */
`timescale 1ns / 1ps

module pled_wave
  import pled_pkg::*;
#(
  parameter int SLOTS = 768,
  parameter int AW = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pled_cfg_t        cfg,
  input  pled_wave_ctl_t   ctl,
  input  logic [LANES-1:0] slot_word,
  output logic [AW-1:0]    slot_addr_nxt,
  output pled_wave_sts_t   sts
);

  logic [1:0]    phase_r, phase_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [16:0]   tick_inc;
  logic [11:0]   bit_limit;
  logic [15:0]   gap_limit;

  assign bit_limit = (cfg.bit_ticks == '0) ? 12'd1 : cfg.bit_ticks;
  assign gap_limit = (cfg.reset_gap_ticks == '0) ? 16'd1 : cfg.reset_gap_ticks;
  assign tick_inc  = {1'b0, tick_r} + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    slot_nxt  = slot_r;
    tick_nxt  = tick_r;
    if (ctl.paint && (phase_r == PHASE_IDLE)) begin
      phase_nxt = PHASE_SEND;
      slot_nxt  = '0;
      tick_nxt  = '0;
    end else if (ctl.tick) begin
      if (phase_r == PHASE_SEND) begin
        tick_nxt = tick_inc[15:0];
        if (tick_inc >= {5'd0, bit_limit}) begin
          tick_nxt = '0;
          if (slot_r == AW'(SLOTS - 1)) begin
            slot_nxt  = '0;
            phase_nxt = PHASE_GAP;
          end else begin
            slot_nxt = slot_r + AW'(1);
          end
        end
      end else if (phase_r == PHASE_GAP) begin
        tick_nxt = tick_inc[15:0];
        if (tick_inc >= {1'b0, gap_limit}) begin
          tick_nxt  = '0;
          phase_nxt = PHASE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      slot_r  <= '0;
      tick_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      tick_r  <= tick_nxt;
    end
  end

  always_comb begin
    if ((phase_r != PHASE_SEND) || (tick_r >= {4'd0, cfg.one_high_ticks})) begin
      sts.level = '0;
    end else if (tick_r < {4'd0, cfg.zero_high_ticks}) begin
      sts.level = '1;
    end else begin
      // stored bits are inverted: a 0 in the store keeps the lane high
      sts.level = ~slot_word;
    end
    sts.sending     = (phase_r != PHASE_IDLE);
    sts.sending_nxt = (phase_nxt != PHASE_IDLE);
    sts.paint_ok    = ctl.paint && (phase_r == PHASE_IDLE);
  end

  assign slot_addr_nxt = slot_nxt;

endmodule

/* rtl/parallel_led_strip_driver_core.sv */
`timescale 1ns / 1ps

// Eight-lane LED strip driver with a bit-plane store of 24*LEDS_PER_LANE slots.
// A tick transaction leaves busy low, so ticks may be issued every clock; its result
// shows the lane levels driven during that tick. Set pixel holds busy for
// 24 read-modify-writes through the store's single write port, or only for the
// finish state for a pixel off the grid; clear holds it while every store entry
// is written (one store entry written per cycle), paint for the finish state.
// After reset, busy is high while the store's SLOTS entries (768 by default)
// are swept to all ones. Each result appears on out_data flagged by out_valid
// for exactly one cycle, in the cycle after the transaction finishes; the receiver
// cannot stall it, so capture out_data whenever out_valid is high.
module parallel_led_strip_driver_core
  import pled_pkg::*;
#(
  parameter int LEDS_PER_LANE = 32,
  parameter int GRID_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  pled_in_t    in_data,
  output logic        out_valid,
  output pled_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int SLOTS = COLOUR_BITS * LEDS_PER_LANE;
  localparam int AW = $clog2(SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CLR  = 2'd1;
  localparam logic [1:0] ST_PIX  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic                   clr_emit_r, clr_emit_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  logic [4:0]             wk_r, wk_nxt;
  logic                   pend_r, pend_nxt;
  logic [AW-1:0]          base_r, base_nxt;
  logic [COLOUR_BITS-1:0] colour_r, colour_nxt;
  logic [LANES-1:0]       mask_r, mask_nxt;
  logic                   paint_ok_r, paint_ok_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pled_out_t              out_data_r, out_data_nxt;
  pled_cfg_t              cfg_r;

  logic             accept;
  logic             pix_ok;
  logic [AW-1:0]    led;
  logic             issue;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [LANES-1:0] mem_wdata;
  logic [AW-1:0]    mem_a_addr;
  logic [LANES-1:0] mem_a_rdata;
  logic [AW-1:0]    mem_b_addr;
  logic [LANES-1:0] mem_b_rdata;
  pled_wave_ctl_t   wave_ctl;
  pled_wave_sts_t   wave_sts;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks       <= BIT_TICKS_RST;
      cfg_r.zero_high_ticks <= ZERO_HIGH_TICKS_RST;
      cfg_r.one_high_ticks  <= ONE_HIGH_TICKS_RST;
      cfg_r.reset_gap_ticks <= RESET_GAP_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_TICKS:       cfg_r.bit_ticks <= cfg_wdata[11:0];
        CFG_ZERO_HIGH_TICKS: cfg_r.zero_high_ticks <= cfg_wdata[11:0];
        CFG_ONE_HIGH_TICKS:  cfg_r.one_high_ticks <= cfg_wdata[11:0];
        CFG_RESET_GAP_TICKS: cfg_r.reset_gap_ticks <= cfg_wdata;
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  assign pix_ok = (in_data.row < GRID_SIZE) && (in_data.column < GRID_SIZE) &&
                  (in_data.row[7:1] < LANES) && (in_data.column < LEDS_PER_LANE);

  // serpentine: odd rows run backwards along the lane
  assign led = in_data.row[0] ? (AW'(LEDS_PER_LANE - 1) - AW'(in_data.column))
                              : AW'(in_data.column);

  assign issue = (cnt_r < 5'(COLOUR_BITS));

  assign wave_ctl.tick  = accept && (in_data.opcode == OP_TICK);
  assign wave_ctl.paint = accept && (in_data.opcode == OP_PAINT);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_emit_nxt  = clr_emit_r;
    cnt_nxt       = cnt_r;
    wk_nxt        = wk_r;
    pend_nxt      = pend_r;
    base_nxt      = base_r;
    colour_nxt    = colour_r;
    mask_nxt      = mask_r;
    paint_ok_nxt  = paint_ok_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr_r;
    mem_wdata     = '1;
    mem_a_addr    = base_r + AW'(cnt_r);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          paint_ok_nxt = 1'b0;
          case (in_data.opcode)
            OP_TICK: begin
              out_valid_nxt               = 1'b1;
              out_data_nxt.lane_levels    = wave_sts.level;
              out_data_nxt.busy_res       = wave_sts.sending_nxt;
              out_data_nxt.paint_accepted = 1'b0;
            end
            OP_PAINT: begin
              paint_ok_nxt = wave_sts.paint_ok;
              state_nxt    = ST_FIN;
            end
            OP_CLEAR: begin
              clr_addr_nxt = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = ST_CLR;
            end
            default: begin
              if (pix_ok) begin
                cnt_nxt    = '0;
                pend_nxt   = 1'b0;
                base_nxt   = (led << 4) + (led << 3);
                colour_nxt = {GAMMA_ROM[in_data.green], GAMMA_ROM[in_data.red],
                              GAMMA_ROM[in_data.blue]};
                mask_nxt   = {{(LANES-1){1'b0}}, 1'b1} << in_data.row[7:1];
                state_nxt  = ST_PIX;
              end else begin
                state_nxt = ST_FIN;
              end
            end
          endcase
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        if (clr_addr_r == AW'(SLOTS - 1)) begin
          state_nxt = clr_emit_r ? ST_FIN : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_PIX: begin
        // read slot k while writing back slot k-1
        if (issue) begin
          cnt_nxt  = cnt_r + 5'd1;
          wk_nxt   = cnt_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we     = 1'b1;
          mem_waddr  = base_r + AW'(wk_r);
          mem_wdata  = colour_r[COLOUR_BITS-1] ? (mem_a_rdata & ~mask_r)
                                               : (mem_a_rdata | mask_r);
          colour_nxt = colour_r << 1;
          if (!issue) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        out_valid_nxt               = 1'b1;
        out_data_nxt.lane_levels    = wave_sts.level;
        out_data_nxt.busy_res       = wave_sts.sending;
        out_data_nxt.paint_accepted = paint_ok_r;
        state_nxt                   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      clr_emit_r  <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      paint_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      paint_ok_r  <= paint_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r       <= wk_nxt;
    base_r     <= base_nxt;
    colour_r   <= colour_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  pled_store #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .a_addr  (mem_a_addr),
    .a_rdata (mem_a_rdata),
    .b_addr  (mem_b_addr),
    .b_rdata (mem_b_rdata)
  );

  pled_wave #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_wave (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .ctl           (wave_ctl),
    .slot_word     (mem_b_rdata),
    .slot_addr_nxt (mem_b_addr),
    .sts           (wave_sts)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/parallel_led_strip_driver_core_tb.sv */
`timescale 1ns / 1ps

module parallel_led_strip_driver_core_tb;
  import pled_pkg::*;

  localparam int GRID = 16;
  localparam int LEDS = 32;
  localparam int SLOTS = COLOUR_BITS * LEDS;
  localparam int BATCH = 96;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  pled_in_t    in_data = '0;
  logic        out_valid;
  pled_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_BIT_TICKS;
  logic [15:0] cfg_wdata = '0;

  parallel_led_strip_driver_core #(
    .LEDS_PER_LANE(LEDS),
    .GRID_SIZE(GRID)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the strip driver
  logic [LANES-1:0] plane_bits [SLOTS];
  logic [11:0] bit_ticks_q;
  logic [11:0] zero_high_q;
  logic [11:0] one_high_q;
  logic [15:0] gap_ticks_q;
  int          slot_idx;
  int          tick_cnt;
  logic [1:0]  wave_phase;

  pled_in_t  pending_txns [$];
  pled_out_t expected_results [$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  txn_count = 0;
  int  frames_started = 0;
  int  pixel_writes = 0;
  int  idle_pct = 0;
  int  taken_cnt = 0;
  int  served_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("parallel_led_strip_driver_core_tb NOT OK");
    $finish;
  end

  function automatic logic [LANES-1:0] lane_level();
    if (wave_phase != PHASE_SEND || slot_idx >= SLOTS) return '0;
    if (tick_cnt >= int'(one_high_q)) return '0;
    if (tick_cnt < int'(zero_high_q)) return '1;
    return ~plane_bits[slot_idx];
  endfunction

  task automatic advance_wave();
    int limit;
    if (wave_phase == PHASE_SEND) begin
      limit = (bit_ticks_q == 0) ? 1 : int'(bit_ticks_q);
      tick_cnt++;
      if (tick_cnt >= limit) begin
        tick_cnt = 0;
        slot_idx++;
        if (slot_idx >= SLOTS) begin
          slot_idx = 0;
          wave_phase = PHASE_GAP;
        end
      end
    end else if (wave_phase == PHASE_GAP) begin
      limit = (gap_ticks_q == 0) ? 1 : int'(gap_ticks_q);
      tick_cnt++;
      if (tick_cnt >= limit) begin
        tick_cnt = 0;
        wave_phase = PHASE_IDLE;
      end
    end
  endtask

  task automatic predict_strip_result(input pled_in_t t);
    pled_out_t   r;
    logic [23:0] colour;
    int          lane;
    int          led;
    int          base;
    r = '0;
    case (t.opcode)
      OP_SET_PIXEL: begin
        if (int'(t.row) < GRID && int'(t.column) < GRID) begin
          lane = int'(t.row) / 2;
          led = t.row[0] ? LEDS - 1 - int'(t.column) : int'(t.column);
          base = COLOUR_BITS * led;
          colour = {GAMMA_ROM[t.green], GAMMA_ROM[t.red], GAMMA_ROM[t.blue]};
          // stored inverted: a one bit clears the lane bit
          for (int k = 0; k < COLOUR_BITS; k++) begin
            plane_bits[base + k][lane] = ~colour[COLOUR_BITS - 1 - k];
          end
        end
        r.lane_levels = lane_level();
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) plane_bits[i] = '1;
        r.lane_levels = lane_level();
      end
      OP_PAINT: begin
        if (wave_phase == PHASE_IDLE) begin
          wave_phase = PHASE_SEND;
          slot_idx = 0;
          tick_cnt = 0;
          r.paint_accepted = 1'b1;
          frames_started++;
        end
        r.lane_levels = lane_level();
      end
      default: begin
        // level during the tick, phase after it
        r.lane_levels = lane_level();
        advance_wave();
      end
    endcase
    r.busy_res = (wave_phase != PHASE_IDLE);
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    pled_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) plane_bits[i] = '1;
      bit_ticks_q = BIT_TICKS_RST;
      zero_high_q = ZERO_HIGH_TICKS_RST;
      one_high_q = ONE_HIGH_TICKS_RST;
      gap_ticks_q = RESET_GAP_TICKS_RST;
      slot_idx = 0;
      tick_cnt = 0;
      wave_phase = PHASE_IDLE;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: levels %h busy %b accepted %b",
                     out_data.lane_levels, out_data.busy_res, out_data.paint_accepted);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.lane_levels !== out_data.lane_levels ||
              want.busy_res !== out_data.busy_res ||
              want.paint_accepted !== out_data.paint_accepted) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: expected %h %b %b, got %h %b %b",
                       results_checked, want.lane_levels, want.busy_res,
                       want.paint_accepted, out_data.lane_levels,
                       out_data.busy_res, out_data.paint_accepted);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIT_TICKS:       bit_ticks_q = cfg_wdata[11:0];
          CFG_ZERO_HIGH_TICKS: zero_high_q = cfg_wdata[11:0];
          CFG_ONE_HIGH_TICKS:  one_high_q = cfg_wdata[11:0];
          default:             gap_ticks_q = cfg_wdata;
        endcase
      end
      if (start && !busy) begin
        predict_strip_result(in_data);
        txn_count++;
        if (in_data.opcode == OP_SET_PIXEL) pixel_writes++;
        taken_cnt++;
      end
    end
  end

  always @(negedge clk) begin : driver
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || (taken_cnt != served_cnt)) begin
      served_cnt = taken_cnt;
      if (pending_txns.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= pending_txns.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic pled_in_t make_txn(logic [1:0] op, int row, int column,
                                        int red, int green, int blue);
    pled_in_t t;
    t.opcode = op;
    t.row = 8'(row);
    t.column = 8'(column);
    t.red = 8'(red);
    t.green = 8'(green);
    t.blue = 8'(blue);
    return t;
  endfunction

  function automatic int random_intensity();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(255);
  endfunction

  function automatic pled_in_t random_pixel();
    int row;
    int column;
    // mostly on the grid, now and then anywhere in the field range
    row = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(GRID - 1);
    column = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(GRID - 1);
    return make_txn(OP_SET_PIXEL, row, column, random_intensity(), random_intensity(),
                    random_intensity());
  endfunction

  function automatic pled_in_t random_txn(logic [1:0] op);
    return make_txn(op, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), $urandom_range(255));
  endfunction

  function automatic pled_in_t random_side_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return random_pixel();
    if (pick < 85) return random_txn(OP_PAINT);
    if (pick < 88) return random_txn(OP_CLEAR);
    return random_txn(OP_TICK);
  endfunction

  task automatic wait_drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_txns.size() != 0 || start || expected_results.size() != 0 || busy);
  endtask

  task automatic set_timing(int bits, int zero_high, int one_high, int gap);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BIT_TICKS;
    cfg_wdata <= 16'(bits);
    @(negedge clk);
    cfg_index <= CFG_ZERO_HIGH_TICKS;
    cfg_wdata <= 16'(zero_high);
    @(negedge clk);
    cfg_index <= CFG_ONE_HIGH_TICKS;
    cfg_wdata <= 16'(one_high);
    @(negedge clk);
    cfg_index <= CFG_RESET_GAP_TICKS;
    cfg_wdata <= 16'(gap);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ticks with a sprinkle of pixel writes, paints and clears, then a full pause
  task automatic tick_batch();
    repeat (BATCH) begin
      if ($urandom_range(99) < 2) pending_txns.push_back(random_side_op());
      pending_txns.push_back(random_txn(OP_TICK));
    end
    wait_drain();
  endtask

  task automatic finish_frame();
    do tick_batch(); while (wave_phase != PHASE_IDLE);
  endtask

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // store sweep after reset
    wait_drain();

    // zero registers act as one: every slot shows its data for one tick
    idle_pct = 0;
    set_timing(0, 0, 1, 0);
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 0, 0, 255, 255, 255));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 15, 15, 0, 0, 0));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 1, 0, 128, 64, 200));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 14, 15, 255, 0, 0));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 15, 0, 0, 255, 0));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 16, 3, 255, 255, 255));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 3, 16, 255, 255, 255));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 255, 255, 255, 255, 255));
    pending_txns.push_back(make_txn(OP_PAINT, 0, 0, 0, 0, 0));
    // second paint lands while the frame is going out
    pending_txns.push_back(make_txn(OP_PAINT, 255, 255, 255, 255, 255));
    repeat (6) pending_txns.push_back(make_txn(OP_TICK, 0, 0, 0, 0, 0));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 0, 1, 0, 128, 1));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 0, 0, 0, 0, 0));
    repeat (3) pending_txns.push_back(make_txn(OP_TICK, 255, 255, 255, 255, 255));
    pending_txns.push_back(make_txn(OP_CLEAR, 0, 0, 0, 0, 0));
    repeat (3) pending_txns.push_back(make_txn(OP_TICK, 0, 0, 0, 0, 0));
    pending_txns.push_back(make_txn(OP_SET_PIXEL, 7, 7, 200, 100, 50));
    wait_drain();
    finish_frame();

    // next frame runs through several slot timings
    idle_pct = 52;
    set_timing(3, 1, 2, 1);
    repeat (16) pending_txns.push_back(random_pixel());
    pending_txns.push_back(random_txn(OP_PAINT));
    tick_batch();

    // zero-bit time not before one-bit time
    idle_pct = 38;
    set_timing(2, 2, 1, 2);
    tick_batch();

    // high times beyond the slot
    idle_pct = 52;
    set_timing(2, 4095, 4095, 5);
    tick_batch();

    // one-tick slots, all-low waveform, longest latch gap
    idle_pct = 0;
    set_timing(1, 1, 0, 65535);
    tick_batch();

    // longest slot
    idle_pct = 38;
    set_timing(4095, 100, 3000, 1);
    tick_batch();

    wait_drain();
    repeat (40) @(posedge clk);
    mismatches += expected_results.size();
    $display("covered %0d transactions (%0d pixel writes), %0d frames, %0d results checked",
             txn_count, pixel_writes, frames_started, results_checked);
    $display("six timing settings incl. zero and full-scale registers, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("parallel_led_strip_driver_core_tb OK");
    end else begin
      $display("parallel_led_strip_driver_core_tb NOT OK");
    end
    $finish;
  end

endmodule
